// ===== rtl/dmacre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmacre_pkg
// Shared types and constants for the DMA channel register engine.
// ----------------------------------------------------------------------------
package dmacre_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_STEP  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // access sizes that get special handling; anything else is a dword
    localparam logic [2:0] SZ_BYTE  = 3'd1;
    localparam logic [2:0] SZ_WORD  = 3'd2;
    localparam logic [2:0] SZ_DWORD = 3'd4;

    // register id groups, taken from id bits 7:4
    localparam logic [3:0] GRP_SOURCE = 4'h0;
    localparam logic [3:0] GRP_TARGET = 4'h1;
    localparam logic [3:0] GRP_COUNT  = 4'h2;

    // nesting level sits at 0x3C (low byte) and 0x3D (high byte)
    localparam logic [7:0] NEST_ID = 8'h3C;

    // channel step modes, config bits 4:2
    localparam logic [2:0] MODE_TGT_INC  = 3'd0;
    localparam logic [2:0] MODE_TGT_DEC  = 3'd1;
    localparam logic [2:0] MODE_SRC_INC  = 3'd2;
    localparam logic [2:0] MODE_SRC_DEC  = 3'd3;
    localparam logic [2:0] MODE_FIXED    = 3'd4;
    localparam logic [2:0] MODE_SRC_STEP = 3'd5;

    localparam int ADDR_W = 24;

    typedef struct packed {
        logic              channel_done;
        logic [2:0]        transfer_bytes;
        logic [ADDR_W-1:0] transfer_target;
        logic [ADDR_W-1:0] transfer_source;
        logic [31:0]       read_data;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/dmacre_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmacre_regfile
// Channel register file with control-register access and DMA step logic.
// ----------------------------------------------------------------------------
module dmacre_regfile
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire dmacre_pkg::func_t func,
    input  wire logic [7:0]        register_id,
    input  wire logic [2:0]        access_size,
    input  wire logic [31:0]       write_value,
    input  wire logic [1:0]        dma_channel,
    output dmacre_pkg::result_t    result
);

    logic [31:0] src_reg [4];
    logic [31:0] tgt_reg [4];
    logic [31:0] cm_reg  [4];
    logic [15:0] nest_reg;

    logic [31:0] src_next;
    logic [31:0] tgt_next;
    logic [31:0] cm_next;
    logic [15:0] nest_next;
    logic        src_we;
    logic        tgt_we;
    logic        cm_we;
    logic        nest_we;

    logic        is_step;
    logic        is_write;
    logic [1:0]  sel_ch;
    logic [31:0] cur_src;
    logic [31:0] cur_tgt;
    logic [31:0] cur_cm;
    logic        is_nest;
    logic        forbid;
    logic        mapped;
    logic [31:0] cur_word;
    logic [31:0] rd_word;
    logic [31:0] wr_word;
    logic [15:0] wr_nest;
    logic [2:0]  mode;
    logic [2:0]  bytes;
    logic [31:0] bytes32;
    logic [31:0] step_src;
    logic [31:0] step_tgt;
    logic [15:0] cnt_dec;
    logic        moves;

    // one channel index serves both register access and stepping
    assign is_step  = (func == dmacre_pkg::FUNC_STEP);
    assign is_write = (func == dmacre_pkg::FUNC_WRITE);
    assign sel_ch   = is_step ? dma_channel : register_id[3:2];
    assign cur_src  = src_reg[sel_ch];
    assign cur_tgt  = tgt_reg[sel_ch];
    assign cur_cm   = cm_reg[sel_ch];

    assign is_nest = (register_id[7:1] == dmacre_pkg::NEST_ID[7:1]);
    assign forbid  = (access_size == dmacre_pkg::SZ_DWORD) && register_id[1];

    always_comb
    begin
        mapped   = 1'b1;
        cur_word = cur_src;
        unique case (register_id[7:4])
            dmacre_pkg::GRP_SOURCE: cur_word = cur_src;
            dmacre_pkg::GRP_TARGET: cur_word = cur_tgt;
            dmacre_pkg::GRP_COUNT:  cur_word = cur_cm;
            default:                mapped   = 1'b0;
        endcase
    end

    // read path
    always_comb
    begin
        rd_word = 32'd0;
        if (is_nest)
        begin
            if (access_size == dmacre_pkg::SZ_BYTE)
                rd_word = {24'd0, nest_reg[{register_id[0], 3'b000} +: 8]};
            else
                rd_word = {16'd0, nest_reg};
        end
        else if (!forbid && mapped)
        begin
            if (access_size == dmacre_pkg::SZ_BYTE)
                rd_word = {24'd0, cur_word[{register_id[1:0], 3'b000} +: 8]};
            else if (access_size == dmacre_pkg::SZ_WORD)
                rd_word = {16'd0, cur_word[{register_id[1], 4'b0000} +: 16]};
            else
                rd_word = cur_word;
        end
    end

    // write merge by lane
    always_comb
    begin
        wr_word = cur_word;
        if (access_size == dmacre_pkg::SZ_BYTE)
            wr_word[{register_id[1:0], 3'b000} +: 8] = write_value[7:0];
        else if (access_size == dmacre_pkg::SZ_WORD)
            wr_word[{register_id[1], 4'b0000} +: 16] = write_value[15:0];
        else
            wr_word = write_value;

        wr_nest = nest_reg;
        if (access_size == dmacre_pkg::SZ_BYTE)
            wr_nest[{register_id[0], 3'b000} +: 8] = write_value[7:0];
        else
            wr_nest = write_value[15:0];
    end

    // channel step
    assign mode    = cur_cm[20:18];
    assign bytes   = (cur_cm[17:16] == 2'd0) ? 3'd1 :
                     (cur_cm[17:16] == 2'd1) ? 3'd2 : 3'd4;
    assign bytes32 = {29'd0, bytes};
    assign cnt_dec = cur_cm[15:0] - 16'd1;
    assign moves   = (mode <= dmacre_pkg::MODE_FIXED);

    always_comb
    begin
        step_src = cur_src;
        step_tgt = cur_tgt;
        unique case (mode)
            dmacre_pkg::MODE_TGT_INC:  step_tgt = cur_tgt + bytes32;
            dmacre_pkg::MODE_TGT_DEC:  step_tgt = cur_tgt - bytes32;
            dmacre_pkg::MODE_SRC_INC:  step_src = cur_src + bytes32;
            dmacre_pkg::MODE_SRC_DEC:  step_src = cur_src - bytes32;
            dmacre_pkg::MODE_SRC_STEP: step_src = cur_src + 32'd1;
            default:                   ;
        endcase
    end

    // register updates
    always_comb
    begin
        src_we    = 1'b0;
        tgt_we    = 1'b0;
        cm_we     = 1'b0;
        nest_we   = 1'b0;
        src_next  = wr_word;
        tgt_next  = wr_word;
        cm_next   = wr_word;
        nest_next = wr_nest;
        if (step_en)
        begin
            if (is_step)
            begin
                src_we   = 1'b1;
                tgt_we   = 1'b1;
                cm_we    = 1'b1;
                src_next = step_src;
                tgt_next = step_tgt;
                cm_next  = {cur_cm[31:16], cnt_dec};
            end
            else if (is_write)
            begin
                if (is_nest)
                begin
                    nest_we = 1'b1;
                end
                else if (!forbid)
                begin
                    src_we = (register_id[7:4] == dmacre_pkg::GRP_SOURCE);
                    tgt_we = (register_id[7:4] == dmacre_pkg::GRP_TARGET);
                    cm_we  = (register_id[7:4] == dmacre_pkg::GRP_COUNT);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                src_reg[i] <= 32'd0;
                tgt_reg[i] <= 32'd0;
                cm_reg[i]  <= 32'd0;
            end
            nest_reg <= 16'd0;
        end
        else
        begin
            if (src_we)
                src_reg[sel_ch] <= src_next;
            if (tgt_we)
                tgt_reg[sel_ch] <= tgt_next;
            if (cm_we)
                cm_reg[sel_ch] <= cm_next;
            if (nest_we)
                nest_reg <= nest_next;
        end
    end

    always_comb
    begin
        result                 = '0;
        result.read_data       = (func == dmacre_pkg::FUNC_READ) ? rd_word : 32'd0;
        if (is_step)
        begin
            result.channel_done = (cnt_dec == 16'd0);
            if (moves)
            begin
                result.transfer_source = cur_src[dmacre_pkg::ADDR_W-1:0];
                result.transfer_target = cur_tgt[dmacre_pkg::ADDR_W-1:0];
                result.transfer_bytes  = bytes;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dma_channel_register_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dma_channel_register_engine
// Four-channel DMA register engine: register access and channel stepping.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word per transfer: tuser holds the function
//   (read, write, step, no-op), tdata the register id, access size, write
//   value and channel. m_axis returns exactly one result word per command:
//   read data, the transfer source/target (24 bits), byte count and the
//   channel done flag.
//   A command is captured in an input register; when the output register
//   is empty or being taken, the register file is read, updated and the
//   result lands in the output register, which drives m_axis_tvalid.
//   Throughput is one command per cycle while the receiver keeps up; each
//   command's register update is committed in the same edge that loads its
//   result, so the next command already sees it.
//   When the receiver stalls, the result holds in the output register and
//   one more command may wait in the input register; s_axis_tready drops
//   only when both are full.
//   Reset clears all channel words, the nesting level and both valid flags.
// ----------------------------------------------------------------------------
module dma_channel_register_engine
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] register_id, [10:8] access_size, [42:11] write_value,
    // [44:43] dma_channel, [47:45] zero
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] read_data, [55:32] transfer_source, [79:56] transfer_target,
    // [82:80] transfer_bytes, [83] channel_done, [87:84] zero
    output logic [87:0]      m_axis_tdata
);

    logic                in_valid_reg;
    logic                in_valid_next;
    dmacre_pkg::func_t   func_reg;
    logic [7:0]          id_reg;
    logic [2:0]          size_reg;
    logic [31:0]         value_reg;
    logic [1:0]          chan_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    dmacre_pkg::result_t result_reg;
    dmacre_pkg::result_t result_next;

    logic                advance;
    logic                step_en;
    logic                in_fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (step_en)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg  <= dmacre_pkg::func_t'(s_axis_tuser);
            id_reg    <= s_axis_tdata[7:0];
            size_reg  <= s_axis_tdata[10:8];
            value_reg <= s_axis_tdata[42:11];
            chan_reg  <= s_axis_tdata[44:43];
        end
        if (step_en)
            result_reg <= result_next;
    end

    dmacre_regfile u_regfile
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .func        (func_reg),
        .register_id (id_reg),
        .access_size (size_reg),
        .write_value (value_reg),
        .dma_channel (chan_reg),
        .result      (result_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, result_reg};

    // a pending command always reaches the empty output register next cycle
    a_pending_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending command did not produce a result");

    // without a transfer, both addresses read zero
    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[82:80] == 3'd0)
        |-> (m_axis_tdata[79:32] == 48'd0))
        else $error("addresses reported without a transfer");

    // a transfer result never carries read data
    a_move_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[82:80] != 3'd0)
        |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("read data on a step result");

    // byte count is 0, 1, 2 or 4
    a_bytes_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[82:80] == 3'd0 || m_axis_tdata[82:80] == 3'd1 ||
                           m_axis_tdata[82:80] == 3'd2 || m_axis_tdata[82:80] == 3'd4))
        else $error("illegal transfer byte count");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the DMA channel register engine against a cycle-free model of its
// register file: register reads and writes at every size, forbidden and
// unmapped ids, the nesting level, and channel steps in all eight modes.
// The command and result streams both stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import dmacre_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;

    dma_channel_register_engine uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // model copy of the register file
    logic [31:0] source_reg     [4];
    logic [31:0] target_reg     [4];
    logic [31:0] count_mode_reg [4];
    logic [15:0] nest_reg;

    result_t owed_results [$];
    result_t seen_result;
    result_t owed_result;

    bit feed_paced;
    bit drain_paced;
    int mismatches;
    int n_reads, n_writes, n_steps, n_nops, n_moves, n_done;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic result_t apply_command(func_t f, logic [7:0] id, logic [2:0] sz,
                                              logic [31:0] val, logic [1:0] ch);
        result_t     r;
        logic [31:0] w;
        logic [1:0]  wch;
        logic        mapped;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [15:0] cfg;
        logic [15:0] cnt;
        logic [2:0]  nb;
        r = '0;
        wch = id[3:2];
        mapped = 1'b1;
        case (id[7:4])
            GRP_SOURCE: w = source_reg[wch];
            GRP_TARGET: w = target_reg[wch];
            GRP_COUNT:  w = count_mode_reg[wch];
            default:
            begin
                w = '0;
                mapped = 1'b0;
            end
        endcase
        if (f == FUNC_READ)
        begin
            if (id[7:1] == NEST_ID[7:1])
            begin
                if (sz == SZ_BYTE)
                    r.read_data = {24'd0, (id[0] ? nest_reg[15:8] : nest_reg[7:0])};
                else
                    r.read_data = {16'd0, nest_reg};
            end
            else if (mapped && !(sz == SZ_DWORD && id[1]))
            begin
                if (sz == SZ_BYTE)
                    r.read_data = (w >> {id[1:0], 3'b000}) & 32'hFF;
                else if (sz == SZ_WORD)
                    r.read_data = {16'd0, (id[1] ? w[31:16] : w[15:0])};
                else
                    r.read_data = w;
            end
        end
        else if (f == FUNC_WRITE)
        begin
            if (id[7:1] == NEST_ID[7:1])
            begin
                if (sz != SZ_BYTE)
                    nest_reg = val[15:0];
                else if (id[0])
                    nest_reg[15:8] = val[7:0];
                else
                    nest_reg[7:0] = val[7:0];
            end
            else if (mapped && !(sz == SZ_DWORD && id[1]))
            begin
                if (sz == SZ_BYTE)
                    w[{id[1:0], 3'b000} +: 8] = val[7:0];
                else if (sz == SZ_WORD)
                    w[{id[1], 4'b0000} +: 16] = val[15:0];
                else
                    w = val;
                case (id[7:4])
                    GRP_SOURCE: source_reg[wch] = w;
                    GRP_TARGET: target_reg[wch] = w;
                    default:    count_mode_reg[wch] = w;
                endcase
            end
        end
        else if (f == FUNC_STEP)
        begin
            src = source_reg[ch];
            tgt = target_reg[ch];
            cfg = count_mode_reg[ch][31:16];
            case (cfg[1:0])
                2'd0:    nb = 3'd1;
                2'd1:    nb = 3'd2;
                default: nb = 3'd4;
            endcase
            if (cfg[4:2] <= MODE_FIXED)
            begin
                r.transfer_source = src[ADDR_W-1:0];
                r.transfer_target = tgt[ADDR_W-1:0];
                r.transfer_bytes  = nb;
            end
            case (cfg[4:2])
                MODE_TGT_INC:  tgt = tgt + {29'd0, nb};
                MODE_TGT_DEC:  tgt = tgt - {29'd0, nb};
                MODE_SRC_INC:  src = src + {29'd0, nb};
                MODE_SRC_DEC:  src = src - {29'd0, nb};
                MODE_SRC_STEP: src = src + 32'd1;
                default: ;
            endcase
            source_reg[ch] = src;
            target_reg[ch] = tgt;
            cnt = count_mode_reg[ch][15:0] - 16'd1;
            count_mode_reg[ch][15:0] = cnt;
            r.channel_done = (cnt == 16'd0);
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // accepted commands update the model and queue the result they owe
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            owed_results.push_back(apply_command(func_t'(s_axis_tuser), s_axis_tdata[7:0],
                                                 s_axis_tdata[10:8], s_axis_tdata[42:11],
                                                 s_axis_tdata[44:43]));
            case (func_t'(s_axis_tuser))
                FUNC_READ:  n_reads++;
                FUNC_WRITE: n_writes++;
                FUNC_STEP:  n_steps++;
                default:    n_nops++;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_result = m_axis_tdata[83:0];
            if (seen_result.transfer_bytes != 3'd0)
                n_moves++;
            if (seen_result.channel_done)
                n_done++;
            if (owed_results.size() == 0)
            begin
                $error("result word with nothing outstanding: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                owed_result = owed_results.pop_front();
                check_field("read_data", owed_result.read_data, seen_result.read_data);
                check_field("transfer_source", 32'(owed_result.transfer_source),
                            32'(seen_result.transfer_source));
                check_field("transfer_target", 32'(owed_result.transfer_target),
                            32'(seen_result.transfer_target));
                check_field("transfer_bytes", 32'(owed_result.transfer_bytes),
                            32'(seen_result.transfer_bytes));
                check_field("channel_done", 32'(owed_result.channel_done),
                            32'(seen_result.channel_done));
            end
        end
    end

    // result side: stall a random number of cycles ahead of each word
    initial
    begin : drain_side
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = drain_paced ? $urandom_range(0, 18) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue_command(func_t f, logic [7:0] id, logic [2:0] sz, logic [31:0] val,
                                 logic [1:0] ch);
        int gap;
        gap = feed_paced ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ch, val, sz, id};
        s_axis_tuser  <= f;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_register_access();
        // byte, word and dword lanes of channel words
        issue_command(FUNC_WRITE, 8'h00, SZ_DWORD, 32'hFFFF_FFFF, 2'd0);
        issue_command(FUNC_WRITE, 8'h13, SZ_BYTE,  32'h0000_00A5, 2'd0);
        issue_command(FUNC_WRITE, 8'h26, SZ_WORD,  32'h1234_8001, 2'd0);
        issue_command(FUNC_READ,  8'h13, SZ_BYTE,  32'h0, 2'd0);
        issue_command(FUNC_READ,  8'h26, SZ_WORD,  32'h0, 2'd0);
        issue_command(FUNC_READ,  8'h10, SZ_DWORD, 32'h0, 2'd0);
        // size codes outside 1/2/4 act as dword and are never forbidden
        issue_command(FUNC_WRITE, 8'h0C, 3'd0, 32'hDEAD_BEEF, 2'd0);
        issue_command(FUNC_WRITE, 8'h0E, SZ_DWORD, 32'h0, 2'd0);
        issue_command(FUNC_READ,  8'h0E, 3'd7, 32'h0, 2'd0);
        issue_command(FUNC_READ,  8'h0E, SZ_DWORD, 32'h0, 2'd0);
        // unmapped ids
        issue_command(FUNC_WRITE, 8'h30, SZ_DWORD, 32'h5555_AAAA, 2'd0);
        issue_command(FUNC_READ,  8'hFF, SZ_WORD,  32'h0, 2'd0);
        // nesting level: byte lanes, then full width
        issue_command(FUNC_WRITE, 8'h3D, SZ_BYTE, 32'hFFFF_FF7F, 2'd0);
        issue_command(FUNC_WRITE, 8'h3C, SZ_BYTE, 32'h0000_0081, 2'd0);
        issue_command(FUNC_READ,  8'h3D, SZ_BYTE, 32'h0, 2'd0);
        issue_command(FUNC_WRITE, 8'h3C, SZ_DWORD, 32'hABCD_1234, 2'd0);
        issue_command(FUNC_READ,  8'h3D, 3'd5, 32'h0, 2'd0);
        issue_command(FUNC_NOP,   8'h00, SZ_DWORD, 32'hFFFF_FFFF, 2'd3);
    endtask

    task automatic test_channel_modes();
        // first pass modes 0-3, second pass 4-7; counts hit zero or wrap
        issue_command(FUNC_WRITE, 8'h20, SZ_DWORD, 32'h000A_0001, 2'd0);
        issue_command(FUNC_WRITE, 8'h24, SZ_DWORD, 32'h0000_0000, 2'd0);
        issue_command(FUNC_WRITE, 8'h28, SZ_DWORD, 32'h0005_0002, 2'd0);
        issue_command(FUNC_WRITE, 8'h2C, SZ_DWORD, 32'h000F_0001, 2'd0);
        for (int c = 0; c < 4; c++)
            issue_command(FUNC_STEP, 8'h00, SZ_BYTE, 32'h0, 2'(c));
        issue_command(FUNC_WRITE, 8'h22, SZ_WORD, 32'h0000_0013, 2'd0);
        issue_command(FUNC_WRITE, 8'h26, SZ_WORD, 32'h0000_0014, 2'd0);
        issue_command(FUNC_WRITE, 8'h28, SZ_DWORD, 32'h001B_0001, 2'd0);
        issue_command(FUNC_WRITE, 8'h2C, SZ_DWORD, 32'hFFFC_0001, 2'd0);
        for (int c = 0; c < 4; c++)
            issue_command(FUNC_STEP, 8'h00, SZ_BYTE, 32'h0, 2'(c));
    endtask

    task automatic test_random_traffic(int total);
        int          roll;
        func_t       f;
        logic [7:0]  id;
        logic [2:0]  sz;
        logic [31:0] val;
        for (int i = 0; i < total; i++)
        begin
            if (i % 150 == 0)
            begin
                feed_paced  = 1'($urandom_range(0, 1));
                drain_paced = 1'($urandom_range(0, 1));
            end
            roll = $urandom_range(0, 99);
            f = (roll < 30) ? FUNC_STEP : (roll < 60) ? FUNC_WRITE :
                (roll < 95) ? FUNC_READ : FUNC_NOP;
            roll = $urandom_range(0, 9);
            if (roll < 7)
                id = 8'($urandom_range(0, 8'h2F));
            else if (roll == 7)
                id = NEST_ID | 8'($urandom_range(0, 1));
            else
                id = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 2))
                    0:       sz = SZ_BYTE;
                    1:       sz = SZ_WORD;
                    default: sz = SZ_DWORD;
                endcase
            end
            else
                sz = 3'($urandom_range(0, 7));
            val = $urandom;
            // small counts so channels actually reach done
            if (f == FUNC_WRITE && id[7:4] == GRP_COUNT && $urandom_range(0, 1))
                val[15:0] = 16'($urandom_range(0, 3));
            issue_command(f, id, sz, val, 2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_NOP;
        feed_paced    = 1'b1;
        drain_paced   = 1'b1;
        for (int c = 0; c < 4; c++)
        begin
            source_reg[c]     = '0;
            target_reg[c]     = '0;
            count_mode_reg[c] = '0;
        end
        nest_reg = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_register_access();
        test_channel_modes();
        test_random_traffic(1200);

        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("covered %0d reads, %0d writes, %0d no-ops and %0d channel steps",
                 n_reads, n_writes, n_nops, n_steps);
        $display("steps gave %0d moves and %0d channel completions", n_moves, n_done);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
